// ===== hdl/mckw_pkg.sv =====
// Shared types and constants for the multi-channel kick watchdog.
`timescale 1ns / 1ps

package mckw_pkg;

    localparam int OP_W   = 2;
    localparam int CH_W   = 4;
    localparam int NOW_W  = 32;
    localparam int KIND_W = 3;
    localparam int EL_W   = 31;
    localparam int TO_W   = 30;
    localparam int CFG_IDX_W = 1;

    localparam logic [OP_W-1:0] OP_START = 2'd0;
    localparam logic [OP_W-1:0] OP_STOP  = 2'd1;
    localparam logic [OP_W-1:0] OP_KICK  = 2'd2;
    localparam logic [OP_W-1:0] OP_CHECK = 2'd3;

    localparam logic [KIND_W-1:0] KIND_ACK       = 3'd0;
    localparam logic [KIND_W-1:0] KIND_UNARMED   = 3'd1;
    localparam logic [KIND_W-1:0] KIND_ALERT     = 3'd2;
    localparam logic [KIND_W-1:0] KIND_TERMINATE = 3'd3;
    localparam logic [KIND_W-1:0] KIND_DONE      = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TERMINATE = 1'd1;

    localparam logic [TO_W-1:0] TIMEOUT_RESET = 30'd1000;

    // Commands from the sequencer to the datapath.
    typedef struct packed {
        logic op_accept;    // start, stop or kick beat taken
        logic check_start;  // check beat taken: latch time, clear scan index
        logic el_calc;      // register elapsed time of the scanned channel
        logic decide;       // apply the verdict for the scanned channel
        logic idx_next;     // step to the next channel
        logic load_done;    // load the check-done result
    } mckw_cmd_t;

    // Status from the datapath to the sequencer.
    typedef struct packed {
        logic out_free;     // result register can take a new result
        logic armed_at_idx; // scanned channel is armed
        logic idx_last;     // scanned channel is the final one
        logic need_out;     // verdict produces a result
        logic terminate;    // verdict is terminate
    } mckw_stat_t;

endpackage

// ===== hdl/multi_channel_kick_watchdog_unit.sv =====
// Top level of the multi-channel kick watchdog: sequencer plus datapath.
`timescale 1ns / 1ps

//  Channel  Direction  Handshake              Payload
//  in       input      in_valid / in_ready    opcode, channel, now
//  out      output     out_valid / out_ready  kind, channel_out, elapsed, last
//  cfg      input      cfg_write              cfg_index, cfg_data
//
// Start, stop and kick each produce a single result beat.
// A check walks the channels in order through the alive-time memory: a read
// step for an unarmed channel, then read, subtract and decide for an armed one,
// and a final check-done beat unless a terminate verdict ends the check first;
// the input stays not ready until the check ends.
// Reset clears all flags at once; the alive-time memory needs no clearing pass.
// A stalled result register holds the scan in place until the beat is taken.

module multi_channel_kick_watchdog_unit #(
    parameter int CHANNELS  = 16,
    parameter int TIME_BITS = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [mckw_pkg::OP_W-1:0]       opcode,
    input  logic [mckw_pkg::CH_W-1:0]       channel,
    input  logic [mckw_pkg::NOW_W-1:0]      now,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [mckw_pkg::KIND_W-1:0]     kind,
    output logic [mckw_pkg::CH_W-1:0]       channel_out,
    output logic [mckw_pkg::EL_W-1:0]       elapsed,
    output logic                            last,
    input  logic                            cfg_write,
    input  logic [mckw_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mckw_pkg::TO_W-1:0]       cfg_data
);

    // Commands flow from the sequencer to the datapath, status flows back.
    mckw_pkg::mckw_cmd_t  cmd;
    mckw_pkg::mckw_stat_t stat;

    // The sequencer owns the halt state: after a terminate beat every input
    // beat is still taken but dropped, while configuration writes go on.
    mckw_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .opcode   (opcode),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // The datapath keeps the flags, the alive times, the configuration and
    // the single result register that decouples the two sides.
    mckw_datapath #(
        .CHANNELS  (CHANNELS),
        .TIME_BITS (TIME_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .opcode      (opcode),
        .channel     (channel),
        .now         (now),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .out_ready   (out_ready),
        .out_valid   (out_valid),
        .kind        (kind),
        .channel_out (channel_out),
        .elapsed     (elapsed),
        .last        (last)
    );

endmodule

// ===== hdl/mckw_ctrl.sv =====
// Sequencer for the watchdog: input acceptance, channel scan and halt state.
`timescale 1ns / 1ps

module mckw_ctrl (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic [mckw_pkg::OP_W-1:0]  opcode,
    output logic                       in_ready,
    input  mckw_pkg::mckw_stat_t       stat,
    output mckw_pkg::mckw_cmd_t        cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD   = 3'd1;
    localparam logic [2:0] S_EL   = 3'd2;
    localparam logic [2:0] S_DEC  = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       halted_reg;
    logic       halted_next;
    logic       take;

    // A halted block still takes beats, but drops them.
    assign in_ready = (state_reg == S_IDLE) && (halted_reg || stat.out_free);
    assign take     = in_valid && in_ready && !halted_reg;

    always_comb
    begin
        state_next  = state_reg;
        halted_next = halted_reg;
        cmd         = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (take)
                begin
                    if (opcode == mckw_pkg::OP_CHECK)
                    begin
                        cmd.check_start = 1'b1;
                        state_next      = S_RD;
                    end
                    else
                    begin
                        cmd.op_accept = 1'b1;
                    end
                end
            end
            S_RD:
            begin
                if (stat.armed_at_idx)
                begin
                    state_next = S_EL;
                end
                else if (stat.idx_last)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.idx_next = 1'b1;
                end
            end
            S_EL:
            begin
                cmd.el_calc = 1'b1;
                state_next  = S_DEC;
            end
            S_DEC:
            begin
                if (!stat.need_out || stat.out_free)
                begin
                    cmd.decide = 1'b1;
                    if (stat.terminate)
                    begin
                        halted_next = 1'b1;
                        state_next  = S_IDLE;
                    end
                    else if (stat.idx_last)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        cmd.idx_next = 1'b1;
                        state_next   = S_RD;
                    end
                end
            end
            S_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.load_done = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            halted_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            halted_reg <= halted_next;
        end
    end

endmodule

// ===== hdl/mckw_datapath.sv =====
// Watchdog datapath: channel flags, alive-time memory, elapsed arithmetic, result register.
`timescale 1ns / 1ps

module mckw_datapath #(
    parameter int CHANNELS  = 16,
    parameter int TIME_BITS = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  mckw_pkg::mckw_cmd_t             cmd,
    output mckw_pkg::mckw_stat_t            stat,
    input  logic [mckw_pkg::OP_W-1:0]       opcode,
    input  logic [mckw_pkg::CH_W-1:0]       channel,
    input  logic [mckw_pkg::NOW_W-1:0]      now,
    input  logic                            cfg_write,
    input  logic [mckw_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mckw_pkg::TO_W-1:0]       cfg_data,
    input  logic                            out_ready,
    output logic                            out_valid,
    output logic [mckw_pkg::KIND_W-1:0]     kind,
    output logic [mckw_pkg::CH_W-1:0]       channel_out,
    output logic [mckw_pkg::EL_W-1:0]       elapsed,
    output logic                            last
);

    localparam int IDXW = $clog2(CHANNELS);
    localparam int CW   = (TIME_BITS > mckw_pkg::EL_W) ? TIME_BITS : mckw_pkg::EL_W;
    localparam logic [IDXW-1:0] IDX_LAST = IDXW'(CHANNELS - 1);

    // Configuration registers.
    logic [mckw_pkg::TO_W-1:0] timeout_reg;
    logic                      term_reg;

    // Per-channel flags.
    logic [CHANNELS-1:0] armed_reg,  armed_next;
    logic [CHANNELS-1:0] kicked_reg, kicked_next;
    logic [CHANNELS-1:0] known_reg,  known_next;
    logic [CHANNELS-1:0] alerted_reg, alerted_next;

    // Alive-time store, no reset: guarded by the known flags.
    logic [TIME_BITS-1:0] alive_mem [CHANNELS];
    logic [TIME_BITS-1:0] rd_data_reg;

    logic [IDXW-1:0]      idx_reg;
    logic [TIME_BITS-1:0] now_reg;
    logic [TIME_BITS-1:0] el_reg;
    logic [4:0]           alert_cnt_reg;

    // Result register.
    logic                          out_valid_reg;
    logic [mckw_pkg::KIND_W-1:0]   kind_reg;
    logic [mckw_pkg::CH_W-1:0]     ch_out_reg;
    logic [mckw_pkg::EL_W-1:0]     el_out_reg;
    logic                          last_reg;

    // Width adaptation.
    logic [IDXW+mckw_pkg::CH_W-1:0] ch_wide;
    logic [IDXW-1:0]                ch_idx;
    logic                           ch_valid;
    logic [IDXW+mckw_pkg::CH_W-1:0] idx_wide;
    logic [TIME_BITS+mckw_pkg::NOW_W-1:0] now_wide;
    logic [TIME_BITS+mckw_pkg::EL_W-1:0]  el_wide;
    logic [CW-1:0]                  el_ext;
    logic [CW+mckw_pkg::EL_W-1:0]   twice_wide;
    logic [CW+mckw_pkg::EL_W-1:0]   tout_wide;

    // Verdict for the scanned channel.
    logic a_armed, a_kicked, a_known, a_alerted;
    logic resync, hung, write_alive, emit_alert, mark_alert;

    logic out_free;
    logic load_op;

    assign ch_wide  = {{IDXW{1'b0}}, channel};
    assign ch_idx   = ch_wide[IDXW-1:0];
    assign ch_valid = ch_wide < (IDXW + mckw_pkg::CH_W)'(CHANNELS);
    assign idx_wide = {{mckw_pkg::CH_W{1'b0}}, idx_reg};
    assign now_wide = {{TIME_BITS{1'b0}}, now};

    assign el_wide    = {{mckw_pkg::EL_W{1'b0}}, el_reg};
    assign el_ext     = el_wide[CW-1:0];
    assign twice_wide = {{CW{1'b0}}, timeout_reg, 1'b0};
    assign tout_wide  = {{(CW + 1){1'b0}}, timeout_reg};

    assign a_armed   = armed_reg[idx_reg];
    assign a_kicked  = kicked_reg[idx_reg];
    assign a_known   = known_reg[idx_reg];
    assign a_alerted = alerted_reg[idx_reg];

    // A wrapped (negative) or implausibly long gap resynchronises the channel.
    assign resync = el_reg[TIME_BITS-1] || (el_ext > twice_wide[CW-1:0]);
    assign hung   = a_armed && !a_kicked && a_known && !resync
                    && (el_ext > tout_wide[CW-1:0]);
    assign write_alive = a_armed && (a_kicked || !a_known || resync);
    assign mark_alert  = hung && !term_reg && !a_alerted;
    assign emit_alert  = mark_alert && !alert_cnt_reg[4];

    assign out_free = !out_valid_reg || out_ready;
    assign load_op  = cmd.op_accept;

    assign stat.out_free     = out_free;
    assign stat.armed_at_idx = a_armed;
    assign stat.idx_last     = (idx_reg == IDX_LAST);
    assign stat.need_out     = (hung && term_reg) || emit_alert;
    assign stat.terminate    = hung && term_reg;

    // Flag updates from register beats and from the scan.
    always_comb
    begin
        armed_next   = armed_reg;
        kicked_next  = kicked_reg;
        known_next   = known_reg;
        alerted_next = alerted_reg;
        if (load_op && ch_valid)
        begin
            case (opcode)
                mckw_pkg::OP_START:
                begin
                    if (!armed_reg[ch_idx])
                    begin
                        armed_next[ch_idx]   = 1'b1;
                        kicked_next[ch_idx]  = 1'b0;
                        known_next[ch_idx]   = 1'b0;
                        alerted_next[ch_idx] = 1'b0;
                    end
                end
                mckw_pkg::OP_STOP:
                begin
                    armed_next[ch_idx] = 1'b0;
                end
                mckw_pkg::OP_KICK:
                begin
                    if (armed_reg[ch_idx])
                    begin
                        kicked_next[ch_idx] = 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end
        if (cmd.decide && a_armed)
        begin
            if (a_kicked)
            begin
                kicked_next[idx_reg]  = 1'b0;
                known_next[idx_reg]   = 1'b1;
                alerted_next[idx_reg] = 1'b0;
            end
            else if (!a_known)
            begin
                known_next[idx_reg] = 1'b1;
            end
            else if (mark_alert)
            begin
                alerted_next[idx_reg] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg   <= mckw_pkg::TIMEOUT_RESET;
            term_reg      <= 1'b0;
            armed_reg     <= '0;
            kicked_reg    <= '0;
            known_reg     <= '0;
            alerted_reg   <= '0;
            idx_reg       <= '0;
            alert_cnt_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    mckw_pkg::CFG_TIMEOUT:   timeout_reg <= cfg_data;
                    mckw_pkg::CFG_TERMINATE: term_reg    <= cfg_data[0];
                    default:
                    begin
                    end
                endcase
            end
            armed_reg   <= armed_next;
            kicked_reg  <= kicked_next;
            known_reg   <= known_next;
            alerted_reg <= alerted_next;

            if (cmd.check_start)
            begin
                idx_reg       <= '0;
                alert_cnt_reg <= '0;
            end
            else if (cmd.idx_next)
            begin
                idx_reg <= idx_reg + 1'b1;
            end
            if (cmd.decide && emit_alert)
            begin
                alert_cnt_reg <= alert_cnt_reg + 1'b1;
            end

            if (load_op || cmd.load_done || (cmd.decide && stat.need_out))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.check_start)
        begin
            now_reg <= now_wide[TIME_BITS-1:0];
        end
        if (cmd.el_calc)
        begin
            el_reg <= now_reg - rd_data_reg;
        end
        if (load_op)
        begin
            kind_reg   <= (opcode == mckw_pkg::OP_KICK && !(ch_valid && armed_reg[ch_idx]))
                          ? mckw_pkg::KIND_UNARMED : mckw_pkg::KIND_ACK;
            ch_out_reg <= channel;
            el_out_reg <= '0;
            last_reg   <= 1'b1;
        end
        else if (cmd.load_done)
        begin
            kind_reg   <= mckw_pkg::KIND_DONE;
            ch_out_reg <= '0;
            el_out_reg <= '0;
            last_reg   <= 1'b1;
        end
        else if (cmd.decide && stat.need_out)
        begin
            kind_reg   <= term_reg ? mckw_pkg::KIND_TERMINATE : mckw_pkg::KIND_ALERT;
            ch_out_reg <= idx_wide[mckw_pkg::CH_W-1:0];
            el_out_reg <= el_ext[mckw_pkg::EL_W-1:0];
            last_reg   <= term_reg;
        end
    end

    // Alive-time memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (cmd.decide && write_alive)
        begin
            alive_mem[idx_reg] <= now_reg;
        end
        rd_data_reg <= alive_mem[idx_reg];
    end

    assign out_valid   = out_valid_reg;
    assign kind        = kind_reg;
    assign channel_out = ch_out_reg;
    assign elapsed     = el_out_reg;
    assign last        = last_reg;

endmodule

// ===== hdl/mckw_checker.sv =====
// Port-level checker for the watchdog and its bind to the top level.
`timescale 1ns / 1ps

module mckw_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            out_valid,
    input logic                            out_ready,
    input logic [mckw_pkg::KIND_W-1:0]     kind,
    input logic [mckw_pkg::CH_W-1:0]       channel_out,
    input logic [mckw_pkg::EL_W-1:0]       elapsed,
    input logic                            last
);

    // A stalled result beat keeps its payload.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(kind)
            && $stable(channel_out) && $stable(elapsed) && $stable(last))
        else $error("result beat changed while stalled");

    // Check done closes a check and carries no channel or time.
    a_done_form: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == mckw_pkg::KIND_DONE |->
            last && channel_out == '0 && elapsed == '0)
        else $error("malformed check-done beat");

    // An alert is never the final beat and always reports a positive gap.
    a_alert_form: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == mckw_pkg::KIND_ALERT |-> !last && elapsed != '0)
        else $error("malformed alert beat");

    // Acks and kick errors are single beats with no elapsed time.
    a_ack_form: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind == mckw_pkg::KIND_ACK || kind == mckw_pkg::KIND_UNARMED)
            |-> last && elapsed == '0)
        else $error("malformed ack beat");

    // Once a terminate beat is taken the block falls silent.
    a_halt_silent: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && kind == mckw_pkg::KIND_TERMINATE |=> !out_valid)
        else $error("result after terminate");

endmodule

bind multi_channel_kick_watchdog_unit mckw_checker u_mckw_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .kind        (kind),
    .channel_out (channel_out),
    .elapsed     (elapsed),
    .last        (last)
);
